// ----- rtl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// shared types and constants of the barometric sensor compensation core
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned DivWidth = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [16:0] DefaultSeaLevel = 17'd101325;
  localparam logic signed [31:0] FineOffset  = 32'sd64000;
  localparam logic signed [31:0] RoundHalf   = 32'sd128;
  localparam logic signed [31:0] PressBase   = 32'sd1048576;
  localparam logic signed [31:0] PressScale  = 32'sd3125;
  localparam logic signed [31:0] DivOffset   = 32'sd32768;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  // floor(x / 1000) = (x * Recip1000) >> Recip1000Shift for any 32-bit x
  localparam logic [31:0] Recip1000      = 32'h1062_4DD3;
  localparam int unsigned Recip1000Shift = 38;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_CALIB  = 3'd0,
    CFG_PRESS_LOW   = 3'd1,
    CFG_PRESS_HIGH  = 3'd2,
    CFG_PRESS_NINE  = 3'd3,
    CFG_ALT_SCALE   = 3'd4
  } cfg_idx_e;

  // fields riding alongside the divider
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        sea_ref;
    logic               pvalid;
    logic               post_dbl;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/bsc_if.sv -----
// ----------------------------------------------------------------------------
// bsc_if
// channel interfaces: sample in, result out, configuration write
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [16:0] sea_level;
  modport source (output valid, raw_temp, raw_press, sea_level, input ready);
  modport sink   (input valid, raw_temp, raw_press, sea_level, output ready);
endinterface

interface bsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_centi;
  logic [31:0]        press_pa;
  logic               press_valid;
  logic [31:0]        altitude_ft;
  modport source (output valid, temp_centi, press_pa, press_valid, altitude_ft,
                  input ready);
  modport sink   (input valid, temp_centi, press_pa, press_valid, altitude_ft,
                  output ready);
endinterface

interface bsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/baro_sensor_compensation_core.sv -----
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// pipelined 32-bit integer temperature, pressure and altitude compensation
// ----------------------------------------------------------------------------
// channel    dir  words
// sample_i   in   raw_temp, raw_press, sea_level
// result_o   out  temp_centi, press_pa, press_valid, altitude_ft
// cfg_i      in   index, data (calibration registers)
//
// one word accepted per cycle while the output is not stalled
// the pipeline is the 32-stage divider plus 16 arithmetic stages
// every stage advances together; a stalled output stalls the whole pipeline
// reset clears valid bits and calibration registers
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_core
  import bsc_pkg::*;
#(
  parameter int unsigned DivW = DivWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bsc_in_if.sink    sample_i,
  bsc_out_if.source result_o,
  bsc_cfg_if.sink   cfg_i
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_nine_q, alt_scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_nine_q <= '0;
      alt_scale_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TEMP_CALIB: temp_calib_q <= cfg_i.data[47:0];
        CFG_PRESS_LOW:  press_low_q  <= cfg_i.data;
        CFG_PRESS_HIGH: press_high_q <= cfg_i.data;
        CFG_PRESS_NINE: press_nine_q <= cfg_i.data[15:0];
        CFG_ALT_SCALE:  alt_scale_q  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'h0, temp_calib_q[15:0]};
  assign t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
  assign t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
  assign p1 = {16'h0, press_low_q[15:0]};
  assign p2 = {{16{press_low_q[31]}}, press_low_q[31:16]};
  assign p3 = {{16{press_low_q[47]}}, press_low_q[47:32]};
  assign p4 = {{16{press_low_q[63]}}, press_low_q[63:48]};
  assign p5 = {{16{press_high_q[15]}}, press_high_q[15:0]};
  assign p6 = {{16{press_high_q[31]}}, press_high_q[31:16]};
  assign p7 = {{16{press_high_q[47]}}, press_high_q[47:32]};
  assign p8 = {{16{press_high_q[63]}}, press_high_q[63:48]};
  assign p9 = {{16{press_nine_q[15]}}, press_nine_q};

  logic en;
  logic out_valid_q;
  assign en             = !out_valid_q || result_o.ready;
  assign sample_i.ready = en;

  // stage a: capture
  logic               va_q;
  logic signed [31:0] a_x_q, a_d_q;
  logic [19:0]        a_adcp_q;
  logic [16:0]        a_ref_q;
  // stage b
  logic               vb_q;
  logic signed [31:0] b_m1_q, b_dd_q;
  logic [19:0]        b_adcp_q;
  logic [16:0]        b_ref_q;
  // stage c
  logic               vc_q;
  logic signed [31:0] c_a_q, c_m2_q;
  logic [19:0]        c_adcp_q;
  logic [16:0]        c_ref_q;
  // stage d: fine temperature
  logic               vd_q;
  logic signed [31:0] d_fine_q;
  logic [19:0]        d_adcp_q;
  logic [16:0]        d_ref_q;
  // stage e
  logic               ve_q;
  logic signed [31:0] e_temp_q, e_qq_q, e_ap5_q, e_p2a_q;
  logic [19:0]        e_adcp_q;
  logic [16:0]        e_ref_q;
  // stage f
  logic               vf_q;
  logic signed [31:0] f_temp_q, f_b0_q, f_ap5_q, f_m3_q, f_p2a_q;
  logic [19:0]        f_adcp_q;
  logic [16:0]        f_ref_q;
  // stage g
  logic               vg_q;
  logic signed [31:0] g_temp_q, g_b_q, g_s_q;
  logic [19:0]        g_adcp_q;
  logic [16:0]        g_ref_q;
  // stage h
  logic               vh_q;
  logic signed [31:0] h_temp_q, h_m4_q, h_num_q;
  logic [16:0]        h_ref_q;
  // stage i: divisor and scaled numerator
  logic               vi_q;
  logic signed [31:0] i_temp_q, i_dvs_q, i_pm_q;
  logic [16:0]        i_ref_q;

  logic signed [31:0] e_pa, e_q, f_qq11, f_qq13, g_a, h_b12;
  assign e_pa   = (d_fine_q >>> 1) - FineOffset;
  assign e_q    = e_pa >>> 2;
  assign f_qq11 = e_qq_q >>> 11;
  assign f_qq13 = e_qq_q >>> 13;
  assign g_a    = ((f_m3_q >>> 3) + (f_p2a_q >>> 1)) >>> 18;
  assign h_b12  = g_b_q >>> 12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (en) begin
      va_q <= sample_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q    <= signed'({15'h0, sample_i.raw_temp[19:3]}) - (t1 <<< 1);
      a_d_q    <= signed'({16'h0, sample_i.raw_temp[19:4]}) - t1;
      a_adcp_q <= sample_i.raw_press;
      a_ref_q  <= (sample_i.sea_level == '0) ? DefaultSeaLevel : sample_i.sea_level;

      b_m1_q   <= 32'(a_x_q * t2);
      b_dd_q   <= 32'(a_d_q * a_d_q);
      b_adcp_q <= a_adcp_q;
      b_ref_q  <= a_ref_q;

      c_a_q    <= b_m1_q >>> 11;
      c_m2_q   <= 32'((b_dd_q >>> 12) * t3);
      c_adcp_q <= b_adcp_q;
      c_ref_q  <= b_ref_q;

      d_fine_q <= c_a_q + (c_m2_q >>> 14);
      d_adcp_q <= c_adcp_q;
      d_ref_q  <= c_ref_q;

      e_temp_q <= (32'(d_fine_q * 32'sd5) + RoundHalf) >>> 8;
      e_qq_q   <= 32'(e_q * e_q);
      e_ap5_q  <= 32'(e_pa * p5);
      e_p2a_q  <= 32'(p2 * e_pa);
      e_adcp_q <= d_adcp_q;
      e_ref_q  <= d_ref_q;

      f_temp_q <= e_temp_q;
      f_b0_q   <= 32'(f_qq11 * p6);
      f_m3_q   <= 32'(p3 * f_qq13);
      f_ap5_q  <= e_ap5_q;
      f_p2a_q  <= e_p2a_q;
      f_adcp_q <= e_adcp_q;
      f_ref_q  <= e_ref_q;

      g_temp_q <= f_temp_q;
      g_b_q    <= ((f_b0_q + (f_ap5_q <<< 1)) >>> 2) + (p4 <<< 16);
      g_s_q    <= DivOffset + g_a;
      g_adcp_q <= f_adcp_q;
      g_ref_q  <= f_ref_q;

      h_temp_q <= g_temp_q;
      h_m4_q   <= 32'(g_s_q * p1);
      h_num_q  <= (PressBase - signed'({12'h0, g_adcp_q})) - h_b12;
      h_ref_q  <= g_ref_q;

      i_temp_q <= h_temp_q;
      i_dvs_q  <= h_m4_q >>> 15;
      i_pm_q   <= 32'(h_num_q * PressScale);
      i_ref_q  <= h_ref_q;
    end
  end

  // divider
  side_t            div_side_in, div_side_out;
  logic [DivW-1:0]  div_dividend;
  logic [DivW-1:0]  div_quot;
  logic             div_valid;
  logic             pm_big;

  assign pm_big = (unsigned'(i_pm_q) >= SignBit);
  assign div_dividend = pm_big ? DivW'(unsigned'(i_pm_q))
                               : DivW'({unsigned'(i_pm_q[30:0]), 1'b0});
  assign div_side_in.temp     = i_temp_q;
  assign div_side_in.sea_ref  = i_ref_q;
  assign div_side_in.pvalid   = (i_dvs_q != '0);
  assign div_side_in.post_dbl = pm_big;

  bsc_div #(.Width(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vi_q),
    .dividend_i (div_dividend),
    .divisor_i  (DivW'(unsigned'(i_dvs_q))),
    .side_i     (div_side_in),
    .valid_o    (div_valid),
    .quot_o     (div_quot),
    .side_o     (div_side_out)
  );

  // stage k: quotient, doubled where post_dbl is set
  logic               vk_q, vl_q, vm_q, vn_q, vo_q, vp_q;
  logic [31:0]        k_p_q;
  side_t              k_side_q, l_side_q, m_side_q, n_side_q, o_side_q, p_side_q;
  logic [31:0]        l_p_q, l_qq_q, m_p_q, n_pf_q, o_pf_q;
  logic signed [31:0] l_pb_q, m_m5_q, m_bb_q;
  logic [31:0]        o_am_q;
  logic [31:0]        p_pf_q;
  logic [25:0]        p_alt_q;
  logic [63:0]        alt_prod;
  logic [31:0]        k_quot;
  logic [31:0]        l_q;
  logic signed [31:0] n_corr;

  assign k_quot   = 32'(div_quot);
  assign l_q      = k_p_q >> 3;
  assign n_corr   = ((m_m5_q >>> 12) + m_bb_q + p7) >>> 4;
  assign alt_prod = o_am_q * Recip1000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q        <= 1'b0;
      vl_q        <= 1'b0;
      vm_q        <= 1'b0;
      vn_q        <= 1'b0;
      vo_q        <= 1'b0;
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vk_q        <= div_valid;
      vl_q        <= vk_q;
      vm_q        <= vl_q;
      vn_q        <= vm_q;
      vo_q        <= vn_q;
      vp_q        <= vo_q;
      out_valid_q <= vp_q;
    end
  end

  logic signed [31:0] out_temp_q;
  logic [31:0]        out_press_q, out_alt_q;
  logic               out_pvalid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_p_q    <= div_side_out.post_dbl ? {k_quot[30:0], 1'b0} : k_quot;
      k_side_q <= div_side_out;

      l_p_q    <= k_p_q;
      l_qq_q   <= 32'(l_q * l_q);
      l_pb_q   <= 32'(signed'(k_p_q >> 2) * p8);
      l_side_q <= k_side_q;

      m_p_q    <= l_p_q;
      m_m5_q   <= 32'(p9 * signed'({13'h0, l_qq_q[31:13]}));
      m_bb_q   <= l_pb_q >>> 13;
      m_side_q <= l_side_q;

      n_pf_q   <= m_side_q.pvalid ? m_p_q + unsigned'(n_corr) : '0;
      n_side_q <= m_side_q;

      o_pf_q   <= n_pf_q;
      o_am_q   <= 32'({16'h0, alt_scale_q} * ({15'h0, n_side_q.sea_ref} - n_pf_q));
      o_side_q <= n_side_q;

      p_pf_q   <= o_pf_q;
      p_alt_q  <= alt_prod[63:Recip1000Shift];
      p_side_q <= o_side_q;

      out_temp_q   <= p_side_q.temp;
      out_press_q  <= p_pf_q;
      out_pvalid_q <= p_side_q.pvalid;
      out_alt_q    <= {6'h0, p_alt_q};
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.temp_centi  = out_temp_q;
  assign result_o.press_pa    = out_press_q;
  assign result_o.press_valid = out_pvalid_q;
  assign result_o.altitude_ft = out_alt_q;

  // zero divisor forces zero pressure
  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_pvalid_q |-> out_press_q == '0)
    else $error("pressure not cleared on zero divisor");

  // stalled pipeline keeps its valid bits; checked on stages i, k, p and the output
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({vi_q, vk_q, vp_q, out_valid_q}))
    else $error("pipeline moved during stall");

  // a stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_temp_q)
      && $stable(out_alt_q))
    else $error("result word changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/bsc_div.sv -----
// ----------------------------------------------------------------------------
// bsc_div
// pipelined restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div
  import bsc_pkg::*;
#(
  parameter int unsigned Width = DivWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  input  wire side_t            side_i,
  output logic                  valid_o,
  output logic [Width-1:0]      quot_o,
  output side_t                 side_o
);

  logic [Width-1:0] rem_q  [Width];
  logic [Width-1:0] dvd_q  [Width];
  logic [Width-1:0] dvs_q  [Width];
  logic [Width-1:0] quo_q  [Width];
  side_t            side_q [Width];
  logic [Width-1:0] vld_q;

  for (genvar k = 0; k < Width; k++) begin : g_stage
    logic [Width-1:0] rem_in, dvd_in, dvs_in, quo_in;
    side_t            side_in;
    logic             vld_in;
    logic [Width:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dvd_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, dvd_in[Width-1]};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? Width'(trial - {1'b0, dvs_in}) : trial[Width-1:0];
        dvd_q[k]  <= {dvd_in[Width-2:0], 1'b0};
        dvs_q[k]  <= dvs_in;
        quo_q[k]  <= {quo_in[Width-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quot_o  = quo_q[Width-1];
  assign side_o  = side_q[Width-1];

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the barometric compensation core against an in-bench predictor of
// temperature, pressure and altitude, with random gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import bsc_pkg::*;
();

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_pa;
    logic               press_valid;
    logic [31:0]        altitude_ft;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  bsc_in_if  sample_bus ();
  bsc_out_if result_bus ();
  bsc_cfg_if cfg_bus ();

  baro_sensor_compensation_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus.sink),
    .result_o (result_bus.source),
    .cfg_i    (cfg_bus.sink)
  );

  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [15:0] cal_p9;
  logic [15:0] cal_scale;

  reading_t expected_q[$];
  int       err_count;
  int       words_sent;
  int       words_checked;
  int       invalid_seen;
  bit       sink_busy;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] sfield(logic [63:0] w, int pos);
    logic [15:0] v;
    v = w[pos +: 16];
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                          logic [16:0] sea);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, p, rf;
    reading_t r;
    t1 = {16'h0, cal_temp[15:0]};
    t2 = sfield(cal_temp, 16);
    t3 = sfield(cal_temp, 32);
    p1 = {16'h0, cal_plo[15:0]};
    p2 = sfield(cal_plo, 16);
    p3 = sfield(cal_plo, 32);
    p4 = sfield(cal_plo, 48);
    p5 = sfield(cal_phi, 0);
    p6 = sfield(cal_phi, 16);
    p7 = sfield(cal_phi, 32);
    p8 = sfield(cal_phi, 48);
    p9 = sfield({48'h0, cal_p9}, 0);
    a = asr((({12'h0, adc_t} >> 3) - (t1 << 1)) * t2, 11);
    d = ({12'h0, adc_t} >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    fine = a + b;
    r.temp_centi = asr(fine * 32'd5 + 32'd128, 8);
    a = asr(fine, 1) - 32'd64000;
    q = asr(a, 2);
    b = asr(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * a, 1), 18);
    a = asr((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      p = 0;
      r.press_valid = 1'b0;
    end else begin
      p = ((32'd1048576 - {12'h0, adc_p}) - asr(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      a = asr(p9 * ((q * q) >> 13), 12);
      b = asr((p >> 2) * p8, 13);
      p = p + asr(a + b + p7, 4);
      r.press_valid = 1'b1;
    end
    r.press_pa = p;
    rf = (sea == 0) ? {15'h0, DefaultSeaLevel} : {15'h0, sea};
    r.altitude_ft = ({16'h0, cal_scale} * (rf - p)) / 32'd1000;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    err_count++;
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [16:0] s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      wait_cycles(gap);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.raw_temp  <= t;
    sample_bus.raw_press <= p;
    sample_bus.sea_level <= s;
    do @(posedge clk_i); while (!sample_bus.ready);
    expected_q.push_back(compensate(t, p, s));
    words_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_TEMP_CALIB: cal_temp  = val[47:0];
      CFG_PRESS_LOW:  cal_plo   = val;
      CFG_PRESS_HIGH: cal_phi   = val;
      CFG_PRESS_NINE: cal_p9    = val[15:0];
      CFG_ALT_SCALE:  cal_scale = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    sample_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    wait_cycles(60);
  endtask

  task automatic load_calib(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                            logic [15:0] p9, logic [15:0] sc);
    drain();
    write_reg(CFG_TEMP_CALIB, {16'h0, tc});
    write_reg(CFG_PRESS_LOW, lo);
    write_reg(CFG_PRESS_HIGH, hi);
    write_reg(CFG_PRESS_NINE, {48'h0, p9});
    write_reg(CFG_ALT_SCALE, {48'h0, sc});
    cfg_bus.valid <= 1'b0;
  endtask

  // typical factory trim
  localparam logic [47:0] TypTemp = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypPLo  = {16'd2855, 16'hF53B, 16'hD67A, 16'd36477};
  localparam logic [63:0] TypPHi  = {-16'sd10230, 16'd15500, 16'hFFF9, 16'd140};

  task automatic test_reset_defaults;
    send_sample(20'd519888, 20'd415148, 17'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 17'h1FFFF);
  endtask

  task automatic test_directed_extremes;
    load_calib(TypTemp, TypPLo, TypPHi, 16'd6000, 16'd3281);
    send_sample(20'd519888, 20'd415148, 17'd0);
    send_sample(20'd0, 20'd0, 17'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 17'h1FFFF);
    send_sample(20'hFFFFF, 20'd0, 17'd1);
    send_sample(20'd0, 20'hFFFFF, 17'd101325);
    send_sample(20'd519888, 20'd0, 17'd50000);
    send_sample(20'hAAAAA, 20'h55555, 17'h0AAAA);
    send_sample(20'h55555, 20'hAAAAA, 17'h15555);
    load_calib(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'hFFFF, 16'hFFFF);
    send_sample(20'd0, 20'd0, 17'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 17'h1FFFF);
    send_sample(20'd519888, 20'd415148, 17'd100000);
    load_calib({16'h8000, 16'h8000, 16'h0}, {16'h8000, 16'h8000, 16'h8000, 16'h0},
               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000, 16'h0);
    send_sample(20'd1000, 20'd1000, 17'd0);
    send_sample(20'hFFFFF, 20'h0, 17'h1FFFF);
    load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF, 16'h1);
    send_sample(20'd0, 20'hFFFFF, 17'd0);
    send_sample(20'h80000, 20'h80000, 17'd120000);
  endtask

  task automatic test_random_typical(int n);
    load_calib(TypTemp ^ 48'($urandom_range(0, 255)), TypPLo ^ 64'($urandom_range(0, 255)),
               TypPHi, 16'($urandom), 16'($urandom));
    repeat (n)
      send_sample(20'($urandom_range(400000, 600000)), 20'($urandom_range(200000, 500000)),
                  ($urandom_range(0, 4) == 0) ? 17'd0 : 17'($urandom_range(95000, 105000)));
  endtask

  task automatic test_random_any(int n);
    load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               16'($urandom), 16'($urandom));
    repeat (n)
      send_sample(20'($urandom), 20'($urandom),
                  ($urandom_range(0, 7) == 0) ? 17'd0 : 17'($urandom));
  endtask

  // result checker with random stalls and occasional full-speed stretches
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result word", result_bus.press_pa, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (result_bus.temp_centi !== want.temp_centi)
          report("temp_centi", result_bus.temp_centi, want.temp_centi);
        if (result_bus.press_pa !== want.press_pa)
          report("press_pa", result_bus.press_pa, want.press_pa);
        if (result_bus.press_valid !== want.press_valid)
          report("press_valid", {31'h0, result_bus.press_valid}, {31'h0, want.press_valid});
        if (result_bus.altitude_ft !== want.altitude_ft)
          report("altitude_ft", result_bus.altitude_ft, want.altitude_ft);
        if (!want.press_valid) invalid_seen++;
        words_checked++;
      end
    end
  end

  initial begin
    int gap;
    result_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    sample_bus.valid = 1'b0;
    sample_bus.raw_temp = '0;
    sample_bus.raw_press = '0;
    sample_bus.sea_level = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_TEMP_CALIB;
    cfg_bus.data = '0;
    cal_temp = '0;
    cal_plo = '0;
    cal_phi = '0;
    cal_p9 = '0;
    cal_scale = '0;
    err_count = 0;
    words_sent = 0;
    words_checked = 0;
    invalid_seen = 0;
    rst_ni = 1'b0;
    wait_cycles(9);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_extremes();
    for (int ph = 0; ph < 6; ph++) begin
      test_random_typical(250);
      test_random_any(75);
    end
    drain();

    $display("sent %0d sample words, checked %0d results, %0d with zero divisor",
             words_sent, words_checked, invalid_seen);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/bsc_pkg.sv
rtl/bsc_if.sv
rtl/bsc_div.sv
rtl/baro_sensor_compensation_core.sv
tb/testbench.sv
